@@ rtl/reference_picture_list_manager_top_assert.svh @@
// Assertion macros used by the reference list manager controller.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef REFERENCE_PICTURE_LIST_MANAGER_TOP_ASSERT_SVH
`define REFERENCE_PICTURE_LIST_MANAGER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rplm_pkg.sv @@
package rplm_pkg;

    localparam int SLOT_W     = 5;
    localparam int ORDER_W    = 32;
    localparam int CFG_DATA_W = 5;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;

    localparam logic [CFG_DATA_W-1:0] MAX_REFS_RESET = 5'd16;

    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_COMMIT = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        FT_P   = 2'd0,
        FT_B   = 2'd1,
        FT_I   = 2'd2,
        FT_IDR = 2'd3
    } t_frame;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_UNUSED    = 2'd2,
        ST_NO_SLOT   = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_MAX_REFS      = 1'b0,
        CFG_GOP_HAS_INTER = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BEGIN,
        S_SEARCH,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [SLOT_W-1:0]  slot;
        logic               slot_valid;
    } t_entry;

    typedef struct packed {
        logic load_in;
        logic do_begin;
        logic do_commit;
        logic inc_ptr;
        logic set_unused;
        logic set_miss;
        logic set_hit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic list_used;
        logic list_empty;
        logic hit;
        logic ptr_last;
    } t_dp_sts;

endpackage

@@ rtl/reference_picture_list_manager_top.sv @@
// Sliding-window reference list manager. Each transaction is taken when the controller
// is idle and its result lands in an output register, so a new transaction can be taken
// while the previous result still waits. An accepted begin or commit transaction passes
// through its own state and then the done state, a no-operation request goes straight
// to the done state, and a lookup compares the list entries in the search state, since
// the list is read through a single port one entry per cycle. The done state loads the
// result once the output register is free or its result is being taken, and the next
// transaction is taken after the controller has returned to idle. Configuration
// writes take effect at once and must only be issued while the block is idle.
module reference_picture_list_manager_top #(
    parameter int MAX_REFS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [rplm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_req_type,
    input  logic [1:0]                        i_frame_type,
    input  logic                              i_is_reference,
    input  logic [rplm_pkg::ORDER_W-1:0]      i_picture_order,
    input  logic                              i_list_select,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [rplm_pkg::INDEX_W-1:0]      o_ref_index,
    output logic [rplm_pkg::COUNT_W-1:0]      o_ref_count,
    output logic                              o_recon_valid,
    output logic [rplm_pkg::SLOT_W-1:0]       o_recon_slot,
    output logic                              o_freed_valid,
    output logic [rplm_pkg::SLOT_W-1:0]       o_freed_slot
);
    import rplm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rplm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_req_type  (i_req_type),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rplm_dp #(
        .MAX_REFS (MAX_REFS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_frame_type    (i_frame_type),
        .i_is_reference  (i_is_reference),
        .i_picture_order (i_picture_order),
        .i_list_select   (i_list_select),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_ref_index     (o_ref_index),
        .o_ref_count     (o_ref_count),
        .o_recon_valid   (o_recon_valid),
        .o_recon_slot    (o_recon_slot),
        .o_freed_valid   (o_freed_valid),
        .o_freed_slot    (o_freed_slot)
    );

endmodule

@@ rtl/rplm_dp.sv @@
module rplm_dp #(
    parameter int MAX_REFS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [rplm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                        i_req_type,
    input  logic [1:0]                        i_frame_type,
    input  logic                              i_is_reference,
    input  logic [rplm_pkg::ORDER_W-1:0]      i_picture_order,
    input  logic                              i_list_select,
    input  rplm_pkg::t_dp_cmd                 i_cmd,
    output rplm_pkg::t_dp_sts                 o_sts,
    output logic [1:0]                        o_status,
    output logic [rplm_pkg::INDEX_W-1:0]      o_ref_index,
    output logic [rplm_pkg::COUNT_W-1:0]      o_ref_count,
    output logic                              o_recon_valid,
    output logic [rplm_pkg::SLOT_W-1:0]       o_recon_slot,
    output logic                              o_freed_valid,
    output logic [rplm_pkg::SLOT_W-1:0]       o_freed_slot
);
    import rplm_pkg::*;

    localparam int POOL  = MAX_REFS + 1;
    localparam int LEN_W = $clog2(MAX_REFS + 1);
    localparam int PTR_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int EW    = ((LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W) + 1;

    // Configuration and control state
    logic [CFG_DATA_W-1:0] r_max_refs;
    logic                  r_gop;
    logic [LEN_W-1:0]      r_len,        n_len;
    logic [POOL-1:0]       r_busy,       n_busy;
    t_frame                r_cur_type,   n_cur_type;
    logic                  r_cur_is_ref, n_cur_is_ref;
    logic [ORDER_W-1:0]    r_cur_order,  n_cur_order;
    logic [SLOT_W-1:0]     r_cur_slot,   n_cur_slot;
    logic                  r_cur_sv,     n_cur_sv;

    // Latched transaction and working registers
    t_frame                r_in_ftype;
    logic                  r_in_isref;
    logic [ORDER_W-1:0]    r_in_order;
    logic                  r_in_lsel;
    logic [PTR_W-1:0]      r_ptr;
    t_entry                r_ent [MAX_REFS];

    // Result staging and output register
    t_status               r_res_status,  n_res_status;
    logic [INDEX_W-1:0]    r_res_index,   n_res_index;
    logic                  r_res_recon_v, n_res_recon_v;
    logic [SLOT_W-1:0]     r_res_recon_s, n_res_recon_s;
    logic                  r_res_freed_v, n_res_freed_v;
    logic [SLOT_W-1:0]     r_res_freed_s, n_res_freed_s;
    t_status               r_out_status;
    logic [INDEX_W-1:0]    r_out_index;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_recon_v;
    logic [SLOT_W-1:0]     r_out_recon_s;
    logic                  r_out_freed_v;
    logic [SLOT_W-1:0]     r_out_freed_s;

    logic [LEN_W-1:0]      eff;
    logic [EW-1:0]         cfg_ext;
    logic [POOL-1:0]       busy_pre;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    t_entry                rd_ent;
    logic                  shift_en;
    logic                  evict;
    logic [LEN_W-1:0]      len_tmp;
    logic [LEN_W:0]        ptr_nx;
    logic [COUNT_W-1:0]    ref_count_now;

    function automatic logic [POOL-1:0] slot_mask(input logic [SLOT_W-1:0] s);
        logic [POOL-1:0] m;
        for (int i = 0; i < POOL; i++) begin
            m[i] = (EW'(s) == EW'(i));
        end
        return m;
    endfunction

    // Register zero behaves as one, values above the list depth as the depth.
    always_comb begin
        cfg_ext = EW'(r_max_refs);
        if (cfg_ext == '0) begin
            eff = LEN_W'(1);
        end else if (cfg_ext > EW'(MAX_REFS)) begin
            eff = LEN_W'(MAX_REFS);
        end else begin
            eff = LEN_W'(cfg_ext);
        end
    end

    // Pool state as seen by a begin transaction before a new slot is taken.
    always_comb begin
        busy_pre = r_busy;
        if (r_cur_sv) begin
            busy_pre = busy_pre & ~slot_mask(r_cur_slot);
        end
        if (r_in_ftype == FT_IDR) begin
            busy_pre = '0;
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < POOL; i++) begin
            if (!free_found && !busy_pre[i] && (EW'(i) <= EW'(eff))) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign rd_ent = r_ent[r_ptr];
    assign ptr_nx = (LEN_W + 1)'(r_ptr) + (LEN_W + 1)'(1);

    assign o_sts.list_used  = r_in_lsel ? (r_cur_type == FT_B)
                                        : ((r_cur_type == FT_P) || (r_cur_type == FT_B));
    assign o_sts.list_empty = (r_len == '0);
    assign o_sts.hit        = (rd_ent.order == r_in_order);
    assign o_sts.ptr_last   = (ptr_nx >= {1'b0, r_len});

    always_comb begin
        n_len         = r_len;
        n_busy        = r_busy;
        n_cur_type    = r_cur_type;
        n_cur_is_ref  = r_cur_is_ref;
        n_cur_order   = r_cur_order;
        n_cur_slot    = r_cur_slot;
        n_cur_sv      = r_cur_sv;
        n_res_status  = r_res_status;
        n_res_index   = r_res_index;
        n_res_recon_v = r_res_recon_v;
        n_res_recon_s = r_res_recon_s;
        n_res_freed_v = r_res_freed_v;
        n_res_freed_s = r_res_freed_s;
        shift_en      = 1'b0;
        evict         = 1'b0;
        len_tmp       = r_len;

        if (i_cmd.load_in) begin
            n_res_status  = ST_OK;
            n_res_index   = '0;
            n_res_recon_v = 1'b0;
            n_res_recon_s = '0;
            n_res_freed_v = 1'b0;
            n_res_freed_s = '0;
        end

        if (i_cmd.do_begin) begin
            n_busy       = busy_pre;
            n_cur_sv     = 1'b0;
            n_cur_slot   = '0;
            n_cur_type   = r_in_ftype;
            n_cur_is_ref = r_in_isref;
            n_cur_order  = r_in_order;
            if (r_in_ftype == FT_IDR) begin
                n_len = '0;
            end
            if (r_in_isref && r_gop) begin
                if (free_found) begin
                    n_busy        = busy_pre | slot_mask(free_slot);
                    n_cur_sv      = 1'b1;
                    n_cur_slot    = free_slot;
                    n_res_recon_v = 1'b1;
                    n_res_recon_s = free_slot;
                end else begin
                    n_res_status = ST_NO_SLOT;
                end
            end
        end

        // The pointer already addresses the oldest entry; eviction and
        // insertion at the front happen together in one shift.
        if (i_cmd.do_commit && r_cur_is_ref) begin
            evict = (r_len >= eff) && (r_len != '0);
            if (evict) begin
                if (rd_ent.slot_valid) begin
                    n_res_freed_v = 1'b1;
                    n_res_freed_s = rd_ent.slot;
                    n_busy        = r_busy & ~slot_mask(rd_ent.slot);
                end
                len_tmp = r_len - LEN_W'(1);
            end
            n_len        = len_tmp + LEN_W'(1);
            shift_en     = 1'b1;
            n_cur_sv     = 1'b0;
            n_cur_is_ref = 1'b0;
        end

        if (i_cmd.set_unused) begin
            n_res_status = ST_UNUSED;
        end
        if (i_cmd.set_miss) begin
            n_res_status = ST_NOT_FOUND;
        end
        if (i_cmd.set_hit) begin
            n_res_index = INDEX_W'(r_ptr);
        end
    end

    assign ref_count_now = ((r_cur_type == FT_I) || (r_cur_type == FT_IDR) || !r_gop)
                         ? '0 : COUNT_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_refs   <= MAX_REFS_RESET;
            r_gop        <= 1'b1;
            r_len        <= '0;
            r_busy       <= '0;
            r_cur_type   <= FT_P;
            r_cur_is_ref <= 1'b0;
            r_cur_order  <= '0;
            r_cur_slot   <= '0;
            r_cur_sv     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_REFS:      r_max_refs <= i_cfg_data;
                    CFG_GOP_HAS_INTER: r_gop      <= i_cfg_data[0];
                endcase
            end
            r_len        <= n_len;
            r_busy       <= n_busy;
            r_cur_type   <= n_cur_type;
            r_cur_is_ref <= n_cur_is_ref;
            r_cur_order  <= n_cur_order;
            r_cur_slot   <= n_cur_slot;
            r_cur_sv     <= n_cur_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_ftype <= t_frame'(i_frame_type);
            r_in_isref <= i_is_reference;
            r_in_order <= i_picture_order;
            r_in_lsel  <= i_list_select;
            if (t_req'(i_req_type) == REQ_COMMIT) begin
                r_ptr <= PTR_W'(r_len - LEN_W'(1));
            end else begin
                r_ptr <= '0;
            end
        end else if (i_cmd.inc_ptr) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end

        if (shift_en) begin
            for (int i = MAX_REFS - 1; i > 0; i--) begin
                r_ent[i] <= r_ent[i-1];
            end
            r_ent[0] <= '{order: r_cur_order, slot: r_cur_slot, slot_valid: r_cur_sv};
        end

        r_res_status  <= n_res_status;
        r_res_index   <= n_res_index;
        r_res_recon_v <= n_res_recon_v;
        r_res_recon_s <= n_res_recon_s;
        r_res_freed_v <= n_res_freed_v;
        r_res_freed_s <= n_res_freed_s;

        if (i_cmd.load_out) begin
            r_out_status  <= r_res_status;
            r_out_index   <= r_res_index;
            r_out_count   <= ref_count_now;
            r_out_recon_v <= r_res_recon_v;
            r_out_recon_s <= r_res_recon_s;
            r_out_freed_v <= r_res_freed_v;
            r_out_freed_s <= r_res_freed_s;
        end
    end

    assign o_status      = r_out_status;
    assign o_ref_index   = r_out_index;
    assign o_ref_count   = r_out_count;
    assign o_recon_valid = r_out_recon_v;
    assign o_recon_slot  = r_out_recon_s;
    assign o_freed_valid = r_out_freed_v;
    assign o_freed_slot  = r_out_freed_s;

endmodule

@@ rtl/rplm_ctrl.sv @@
`include "reference_picture_list_manager_top_assert.svh"

module rplm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_req_type,
    input  rplm_pkg::t_dp_sts i_sts,
    output rplm_pkg::t_dp_cmd o_cmd
);
    import rplm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_BEGIN:  n_state = S_BEGIN;
                        REQ_LOOKUP: n_state = S_SEARCH;
                        REQ_COMMIT: n_state = S_COMMIT;
                        REQ_NOP:    n_state = S_DONE;
                    endcase
                end
            end
            S_BEGIN: begin
                o_cmd.do_begin = 1'b1;
                n_state        = S_DONE;
            end
            S_COMMIT: begin
                o_cmd.do_commit = 1'b1;
                n_state         = S_DONE;
            end
            // One list entry is compared per cycle, newest first.
            S_SEARCH: begin
                if (!i_sts.list_used) begin
                    o_cmd.set_unused = 1'b1;
                    n_state          = S_DONE;
                end else if (i_sts.list_empty) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else if (i_sts.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.ptr_last) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.inc_ptr = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `RPLM_ASSERT_NOW(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten before it was taken")
    `RPLM_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state != S_IDLE, "accepted transaction not started")
    `RPLM_ASSERT_NOW(a_out_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "result raised outside completion")
    `RPLM_ASSERT_NOW(a_search_bounded, o_cmd.inc_ptr, !i_sts.ptr_last && !i_sts.list_empty, "search stepped beyond the list")

endmodule

@@ dv/reference_picture_list_manager_top_test.sv @@
module reference_picture_list_manager_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rplm_pkg::*;

    localparam int DEPTH        = 16;
    localparam int POOL         = DEPTH + 1;
    localparam int CLK_PERIOD   = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int DIRECTED     = 24;
    localparam int RANDOM_ITEMS = 1250;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef struct {
        t_status              status;
        logic [INDEX_W-1:0]   ref_index;
        logic [COUNT_W-1:0]   ref_count;
        logic                 recon_valid;
        logic [SLOT_W-1:0]    recon_slot;
        logic                 freed_valid;
        logic [SLOT_W-1:0]    freed_slot;
    } t_answer;

    // Tracks the reference list, the slot pool and the frame in progress, and keeps
    // the answers still awaited from the block in transaction order.
    class ref_list_tracker;
        logic [ORDER_W-1:0]    held_order [DEPTH];
        logic [SLOT_W-1:0]     held_slot [DEPTH];
        bit                    held_has_slot [DEPTH];
        int unsigned           depth_used;
        bit [POOL-1:0]         slot_taken;
        t_frame                frame_kind;
        bit                    frame_is_ref;
        logic [ORDER_W-1:0]    frame_order;
        logic [SLOT_W-1:0]     frame_slot;
        bit                    frame_has_slot;
        logic [CFG_DATA_W-1:0] reg_max_refs;
        bit                    reg_gop_inter;
        t_answer               awaited [$];
        int unsigned           mismatches;
        int unsigned           answers_seen;

        function new();
            foreach (held_order[k]) begin
                held_order[k]    = '0;
                held_slot[k]     = '0;
                held_has_slot[k] = 1'b0;
            end
            depth_used     = 0;
            slot_taken     = '0;
            frame_kind     = FT_P;
            frame_is_ref   = 1'b0;
            frame_order    = '0;
            frame_slot     = '0;
            frame_has_slot = 1'b0;
            reg_max_refs   = MAX_REFS_RESET;
            reg_gop_inter  = 1'b1;
            mismatches     = 0;
            answers_seen   = 0;
        endfunction

        function void set_registers(logic [CFG_DATA_W-1:0] max_refs, bit gop_inter);
            reg_max_refs  = max_refs;
            reg_gop_inter = gop_inter;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Zero behaves as one and anything beyond the list depth as the depth.
        function int unsigned window();
            if (reg_max_refs == 0) return 1;
            if (reg_max_refs > DEPTH) return DEPTH;
            return reg_max_refs;
        endfunction

        function void release_slot(logic [SLOT_W-1:0] s);
            if (s < POOL) slot_taken[s] = 1'b0;
        endfunction

        function logic [ORDER_W-1:0] known_order();
            if (depth_used == 0 || $urandom_range(5) == 0) return $urandom;
            return held_order[$urandom_range(depth_used - 1)];
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] %s", $time, msg);
        endtask

        function void note_request(t_req req, t_frame ft, bit is_ref,
                                   logic [ORDER_W-1:0] ord, bit list_one);
            t_answer a;
            int unsigned pool_size;
            int unsigned last;
            bit found;
            bit used;
            a.status      = ST_OK;
            a.ref_index   = '0;
            a.ref_count   = '0;
            a.recon_valid = 1'b0;
            a.recon_slot  = '0;
            a.freed_valid = 1'b0;
            a.freed_slot  = '0;
            case (req)
                REQ_BEGIN: begin
                    // A frame begun but never committed gives its slot back first.
                    if (frame_has_slot) release_slot(frame_slot);
                    frame_has_slot = 1'b0;
                    frame_slot     = '0;
                    frame_kind     = ft;
                    frame_is_ref   = is_ref;
                    frame_order    = ord;
                    if (ft == FT_IDR) begin
                        depth_used = 0;
                        slot_taken = '0;
                    end
                    if (is_ref && reg_gop_inter) begin
                        pool_size = window() + 1;
                        found     = 1'b0;
                        for (int unsigned s = 0; s < pool_size && !found; s++) begin
                            if (!slot_taken[s]) begin
                                found          = 1'b1;
                                slot_taken[s]  = 1'b1;
                                frame_slot     = SLOT_W'(s);
                                frame_has_slot = 1'b1;
                            end
                        end
                        if (found) begin
                            a.recon_valid = 1'b1;
                            a.recon_slot  = frame_slot;
                        end else begin
                            a.status = ST_NO_SLOT;
                        end
                    end
                end
                REQ_LOOKUP: begin
                    used = list_one ? (frame_kind == FT_B)
                                    : (frame_kind == FT_P || frame_kind == FT_B);
                    if (!used) begin
                        a.status = ST_UNUSED;
                    end else begin
                        found = 1'b0;
                        for (int unsigned k = 0; k < depth_used && !found; k++) begin
                            if (held_order[k] == ord) begin
                                found       = 1'b1;
                                a.ref_index = INDEX_W'(k);
                            end
                        end
                        if (!found) a.status = ST_NOT_FOUND;
                    end
                end
                REQ_COMMIT: begin
                    if (frame_is_ref) begin
                        // Only one entry leaves per commit, even after max_refs shrinks.
                        if (depth_used >= window() && depth_used > 0) begin
                            last = depth_used - 1;
                            if (held_has_slot[last]) begin
                                a.freed_valid = 1'b1;
                                a.freed_slot  = held_slot[last];
                                release_slot(held_slot[last]);
                            end
                            depth_used = last;
                        end
                        if (depth_used > DEPTH - 1) depth_used = DEPTH - 1;
                        for (int unsigned k = depth_used; k > 0; k--) begin
                            held_order[k]    = held_order[k-1];
                            held_slot[k]     = held_slot[k-1];
                            held_has_slot[k] = held_has_slot[k-1];
                        end
                        held_order[0]    = frame_order;
                        held_slot[0]     = frame_slot;
                        held_has_slot[0] = frame_has_slot;
                        depth_used++;
                        frame_has_slot = 1'b0;
                        frame_is_ref   = 1'b0;
                    end
                end
                default: ;
            endcase
            if (frame_kind == FT_I || frame_kind == FT_IDR || !reg_gop_inter)
                a.ref_count = '0;
            else
                a.ref_count = COUNT_W'(depth_used);
            awaited.push_back(a);
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, awaited %0h",
                                 answers_seen, name, got, want));
        endtask

        task check_answer(logic [1:0] st, logic [INDEX_W-1:0] idx,
                          logic [COUNT_W-1:0] cnt, logic rv,
                          logic [SLOT_W-1:0] rs, logic fv,
                          logic [SLOT_W-1:0] fs);
            t_answer a;
            answers_seen++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d arrived with nothing awaited", answers_seen));
                return;
            end
            a = awaited.pop_front();
            compare_field("status", 32'(st), 32'(a.status));
            compare_field("ref_index", 32'(idx), 32'(a.ref_index));
            compare_field("ref_count", 32'(cnt), 32'(a.ref_count));
            compare_field("recon_valid", 32'(rv), 32'(a.recon_valid));
            compare_field("recon_slot", 32'(rs), 32'(a.recon_slot));
            compare_field("freed_valid", 32'(fv), 32'(a.freed_valid));
            compare_field("freed_slot", 32'(fs), 32'(a.freed_slot));
        endtask
    endclass

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_cfg_we        = 1'b0;
    logic                    i_cfg_index     = 1'b0;
    logic [CFG_DATA_W-1:0]   i_cfg_data      = '0;
    logic                    i_in_valid      = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_req_type      = '0;
    logic [1:0]              i_frame_type    = '0;
    logic                    i_is_reference  = 1'b0;
    logic [ORDER_W-1:0]      i_picture_order = '0;
    logic                    i_list_select   = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready     = 1'b1;
    logic [1:0]              o_status;
    logic [INDEX_W-1:0]      o_ref_index;
    logic [COUNT_W-1:0]      o_ref_count;
    logic                    o_recon_valid;
    logic [SLOT_W-1:0]       o_recon_slot;
    logic                    o_freed_valid;
    logic [SLOT_W-1:0]       o_freed_slot;

    ref_list_tracker tracker;
    bit              steady       = 1'b0;
    bit              hold_off_req = 1'b0;
    int unsigned     issued       = 0;
    logic [31:0]     next_order   = '0;

    reference_picture_list_manager_top #(
        .MAX_REFS(DEPTH)
    ) dut (
        .*
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offers one transaction, after an occasional idle stretch, and returns at the
    // edge where it is taken.
    task automatic offer(t_req req, t_frame ft, bit is_ref, logic [ORDER_W-1:0] ord,
                         bit list_one);
        if (!steady && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 22);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_frame_type    <= ft;
        i_is_reference  <= is_ref;
        i_picture_order <= ord;
        i_list_select   <= list_one;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(req, ft, is_ref, ord, list_one);
        issued++;
    endtask

    task automatic program_registers(logic [CFG_DATA_W-1:0] max_refs, bit gop_inter);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_REFS;
        i_cfg_data  <= max_refs;
        @(posedge i_clk);
        // Upper data bits are ignored by the one-bit register, so they carry noise.
        i_cfg_index <= CFG_GOP_HAS_INTER;
        i_cfg_data  <= {4'($urandom_range(15)), gop_inter};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_registers(max_refs, gop_inter);
    endtask

    task automatic run_frame();
        t_frame ft;
        bit is_ref;
        logic [ORDER_W-1:0] ord;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) ft = FT_P;
        else if (pick < 75) ft = FT_B;
        else if (pick < 92) ft = FT_I;
        else ft = FT_IDR;
        is_ref = ($urandom_range(9) != 0);
        if ($urandom_range(19) == 0) begin
            ord = tracker.known_order();
        end else if ($urandom_range(19) == 0) begin
            ord = $urandom;
        end else begin
            ord = next_order;
            next_order += $urandom_range(1, 3);
        end
        offer(REQ_BEGIN, ft, is_ref, ord, 1'($urandom));
        repeat ($urandom_range(0, 4))
            offer(REQ_LOOKUP, t_frame'($urandom_range(3)), 1'($urandom),
                  tracker.known_order(), 1'($urandom));
        offer(REQ_COMMIT, t_frame'($urandom_range(3)), 1'($urandom), $urandom,
              1'($urandom));
    endtask

    initial begin
        int unsigned phase;
        int unsigned waited;
        logic [CFG_DATA_W-1:0] max_refs;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_registers(MAX_REFS_RESET, 1'b1);
        offer(REQ_BEGIN, FT_IDR, 1'b1, 32'd0, 1'b0);
        offer(REQ_LOOKUP, FT_P, 1'b0, 32'd0, 1'b0);
        offer(REQ_COMMIT, FT_P, 1'b0, 32'd0, 1'b0);
        offer(REQ_BEGIN, FT_P, 1'b1, 32'd1, 1'b1);
        offer(REQ_LOOKUP, FT_P, 1'b0, 32'd0, 1'b0);
        offer(REQ_LOOKUP, FT_P, 1'b0, 32'd0, 1'b1);
        offer(REQ_COMMIT, FT_P, 1'b0, 32'd0, 1'b0);
        offer(REQ_BEGIN, FT_B, 1'b0, 32'd2, 1'b0);
        offer(REQ_LOOKUP, FT_B, 1'b0, 32'd1, 1'b1);
        offer(REQ_LOOKUP, FT_B, 1'b0, 32'd0, 1'b0);
        offer(REQ_LOOKUP, FT_B, 1'b0, 32'hFFFF_FFFF, 1'b0);
        offer(REQ_COMMIT, FT_B, 1'b0, 32'd0, 1'b0);
        offer(REQ_BEGIN, FT_P, 1'b1, 32'hFFFF_FFFF, 1'b0);
        // A second begin before the commit gives the first slot back.
        offer(REQ_BEGIN, FT_P, 1'b1, 32'd5, 1'b0);
        offer(REQ_COMMIT, FT_P, 1'b0, 32'd0, 1'b0);
        offer(REQ_COMMIT, FT_P, 1'b0, 32'd0, 1'b0);
        offer(REQ_NOP, FT_IDR, 1'b1, 32'hFFFF_FFFF, 1'b1);
        offer(REQ_BEGIN, FT_I, 1'b1, 32'd7, 1'b0);
        offer(REQ_LOOKUP, FT_I, 1'b0, 32'd7, 1'b0);
        offer(REQ_COMMIT, FT_I, 1'b0, 32'd0, 1'b0);

        // A pool of two with every slot still held by the list: no slot for the next
        // reference, and the commit evicts a single entry.
        program_registers(5'd0, 1'b1);
        offer(REQ_BEGIN, FT_P, 1'b1, 32'd8, 1'b0);
        offer(REQ_COMMIT, FT_P, 1'b0, 32'd0, 1'b0);

        // Without inter frames a reference enters the list with no slot.
        program_registers(5'd31, 1'b0);
        offer(REQ_BEGIN, FT_P, 1'b1, 32'd9, 1'b0);
        offer(REQ_COMMIT, FT_P, 1'b0, 32'd0, 1'b0);

        phase = 0;
        while (issued < DIRECTED + RANDOM_ITEMS) begin
            case (phase)
                0: max_refs = 5'd1;
                1: max_refs = 5'd16;
                2: max_refs = 5'd0;
                3: max_refs = 5'd31;
                default: begin
                    case ($urandom_range(4))
                        0: max_refs = 5'd1;
                        1: max_refs = 5'd16;
                        2: max_refs = 5'd17;
                        default: max_refs = 5'($urandom_range(2, 15));
                    endcase
                end
            endcase
            program_registers(max_refs, phase < 2 || $urandom_range(4) != 0);
            next_order = $urandom;
            steady     = (phase == 2);
            if (phase == 1) hold_off_req = 1'b1;
            repeat ($urandom_range(15, 45)) begin
                if ($urandom_range(9) == 0)
                    offer(t_req'($urandom_range(3)), t_frame'($urandom_range(3)),
                          1'($urandom), $urandom, 1'($urandom));
                else
                    run_frame();
            end
            phase++;
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;

        waited = 0;
        while (tracker.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DEPTH + 4) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: checks each transaction and paces i_out_ready, including one long
    // hold-off so that the block backs up and stalls its input.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                tracker.check_answer(o_status, o_ref_index, o_ref_count, o_recon_valid,
                                     o_recon_slot, o_freed_valid, o_freed_slot);
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                i_out_ready  <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 22);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timed out with %0d results outstanding", tracker.pending());
        $display("status: fail");
        $finish;
    end

endmodule
